### hw/rtl/sravc_pkg.sv
// Shared types and constants for the screen region average color unit.
// No dependencies; imported by the top level and its checker.
package sravc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_MONITOR_LEFT  = 3'd0;
    localparam logic [2:0] REG_MONITOR_TOP   = 3'd1;
    localparam logic [2:0] REG_REGION_X      = 3'd2;
    localparam logic [2:0] REG_REGION_Y      = 3'd3;
    localparam logic [2:0] REG_REGION_WIDTH  = 3'd4;
    localparam logic [2:0] REG_REGION_HEIGHT = 3'd5;
    localparam logic [2:0] REG_SAMPLE_STEP   = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int COORD_W     = 16;
    localparam int SIZE_W      = 14;
    localparam int STEP_W      = 5;
    localparam int PHASE_W     = 4;
    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 32;
    localparam int CNT_W       = 25;
    // Signed width for region edges and pixel positions
    localparam int POS_W       = 19;
    // Divider: numerator 2*sum+count, denominator 2*count
    localparam int REM_W       = SUM_W + 2;
    localparam int DEN_W       = CNT_W + 1;

    localparam logic [CNT_W-1:0]  COUNT_LIMIT = 25'h1000000;
    localparam logic [STEP_W-1:0] STEP_MIN    = 5'd1;
    localparam logic [STEP_W-1:0] STEP_MAX    = 5'd16;
    localparam logic [2:0]        QBIT_TOP    = 3'd7;

    typedef enum logic [1:0] {
        ST_PIXEL,
        ST_LOAD,
        ST_DIV,
        ST_FINISH
    } seq_state_t;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } chan_t;

endpackage

### hw/rtl/screen_region_average_color_unit.sv
// Screen region average color: raster pixel accumulator and shared divider.
// Depends on sravc_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one pixel per beat in raster
//   order with end_of_line and end_of_frame marks. Ordinary pixels are taken
//   one per cycle. A beat with end_of_frame starts the average computation;
//   in_ready stays low until the result is loaded into the output register.
//   Output channel (out_valid/out_ready) carries one beat per frame: three
//   rounded channel averages and the sample count.
//   After the end-of-frame beat, one restoring divider, one quotient bit
//   per cycle, is shared by the three channels in turn (skipped when no
//   pixel was taken); the final state then loads the output register.
//   The block then accepts pixels again at one per cycle while the result
//   waits.
//   If the receiver stalls, the result holds in the output register; a
//   following end of frame waits in the final state until it is taken.
//   Config port (cfg_valid/cfg_ready) is always ready; write it while idle.
//   Reset clears the frame state, the sequencer and the configuration registers (step 1).
module screen_region_average_color_unit #(
    parameter int MAX_LINE_PIXELS = 4096,
    parameter int MAX_LINES       = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sravc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sravc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [sravc_pkg::CHAN_W-1:0]         blue,
    input  logic [sravc_pkg::CHAN_W-1:0]         green,
    input  logic [sravc_pkg::CHAN_W-1:0]         red,
    input  logic                                 end_of_line,
    input  logic                                 end_of_frame,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sravc_pkg::CHAN_W-1:0]         avg_red,
    output logic [sravc_pkg::CHAN_W-1:0]         avg_green,
    output logic [sravc_pkg::CHAN_W-1:0]         avg_blue,
    output logic [sravc_pkg::CNT_W-1:0]          sample_count
);
    import sravc_pkg::*;

    localparam int COL_W = $clog2(MAX_LINE_PIXELS + 1);
    localparam int ROW_W = $clog2(MAX_LINES + 1);

    // Configuration registers
    logic signed [COORD_W-1:0] monitor_left_reg;
    logic signed [COORD_W-1:0] monitor_top_reg;
    logic signed [COORD_W-1:0] region_x_reg;
    logic signed [COORD_W-1:0] region_y_reg;
    logic [SIZE_W-1:0]         region_width_reg;
    logic [SIZE_W-1:0]         region_height_reg;
    logic [STEP_W-1:0]         sample_step_reg;

    // Frame state
    logic [COL_W-1:0]   column_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [PHASE_W-1:0] column_phase_reg;
    logic [PHASE_W-1:0] row_phase_reg;
    logic [SUM_W-1:0]   sum_red_reg;
    logic [SUM_W-1:0]   sum_green_reg;
    logic [SUM_W-1:0]   sum_blue_reg;
    logic [CNT_W-1:0]   taken_reg;

    // Sequencer and divider
    seq_state_t        state_reg;
    seq_state_t        state_next;
    chan_t             ch_reg;
    logic [2:0]        qbit_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [CHAN_W-1:0] quot_reg;
    logic [CHAN_W-1:0] res_red_reg;
    logic [CHAN_W-1:0] res_green_reg;
    logic [CHAN_W-1:0] res_blue_reg;

    // Output register
    logic              out_valid_reg;
    logic [CHAN_W-1:0] avg_red_reg;
    logic [CHAN_W-1:0] avg_green_reg;
    logic [CHAN_W-1:0] avg_blue_reg;
    logic [CNT_W-1:0]  sample_count_reg;

    // Sequencer outputs
    logic div_load;
    logic div_step;
    logic commit;

    logic in_accept;
    logic count_zero;

    assign cfg_ready  = 1'b1;
    assign in_accept  = in_valid && in_ready;
    assign count_zero = (taken_reg == '0);

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            monitor_left_reg  <= '0;
            monitor_top_reg   <= '0;
            region_x_reg      <= '0;
            region_y_reg      <= '0;
            region_width_reg  <= '0;
            region_height_reg <= '0;
            sample_step_reg   <= STEP_MIN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MONITOR_LEFT:  monitor_left_reg  <= cfg_data;
                REG_MONITOR_TOP:   monitor_top_reg   <= cfg_data;
                REG_REGION_X:      region_x_reg      <= cfg_data;
                REG_REGION_Y:      region_y_reg      <= cfg_data;
                REG_REGION_WIDTH:  region_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_REGION_HEIGHT: region_height_reg <= cfg_data[SIZE_W-1:0];
                REG_SAMPLE_STEP:   sample_step_reg   <= cfg_data[STEP_W-1:0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Region edges relative to the frame, and the grid test
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0] x_start;
    logic signed [POS_W-1:0] y_start;
    logic signed [POS_W-1:0] x_end;
    logic signed [POS_W-1:0] y_end;
    logic signed [POS_W-1:0] x_first;
    logic signed [POS_W-1:0] y_first;
    logic signed [POS_W-1:0] col_pos;
    logic signed [POS_W-1:0] row_pos;
    logic [STEP_W-1:0]       step_eff;
    logic                    col_valid;
    logic                    row_valid;
    logic                    col_started;
    logic                    row_started;
    logic                    col_in;
    logic                    row_in;
    logic                    take;
    logic [PHASE_W-1:0]      column_phase_adv;
    logic [PHASE_W-1:0]      row_phase_adv;
    logic [STEP_W-1:0]       column_phase_inc;
    logic [STEP_W-1:0]       row_phase_inc;

    always_comb
    begin
        x_start = POS_W'(region_x_reg) - POS_W'(monitor_left_reg);
        y_start = POS_W'(region_y_reg) - POS_W'(monitor_top_reg);
        x_end   = x_start + $signed({{(POS_W-SIZE_W){1'b0}}, region_width_reg});
        y_end   = y_start + $signed({{(POS_W-SIZE_W){1'b0}}, region_height_reg});
        x_first = x_start[POS_W-1] ? '0 : x_start;
        y_first = y_start[POS_W-1] ? '0 : y_start;
        col_pos = $signed({{(POS_W-COL_W){1'b0}}, column_reg});
        row_pos = $signed({{(POS_W-ROW_W){1'b0}}, row_reg});

        col_valid   = column_reg < COL_W'(MAX_LINE_PIXELS);
        row_valid   = row_reg < ROW_W'(MAX_LINES);
        col_started = col_pos >= x_first;
        row_started = row_pos >= y_first;
        col_in      = col_valid && col_started && (col_pos < x_end);
        row_in      = row_valid && row_started && (row_pos < y_end);
        take        = col_in && row_in && (column_phase_reg == '0)
                      && (row_phase_reg == '0) && (taken_reg < COUNT_LIMIT);

        // Out-of-range steps clamp to 1..16
        if (sample_step_reg == '0)
            step_eff = STEP_MIN;
        else if (sample_step_reg > STEP_MAX)
            step_eff = STEP_MAX;
        else
            step_eff = sample_step_reg;

        column_phase_inc = {1'b0, column_phase_reg} + STEP_MIN;
        row_phase_inc    = {1'b0, row_phase_reg} + STEP_MIN;
        column_phase_adv = (column_phase_inc >= step_eff) ? '0
                           : column_phase_inc[PHASE_W-1:0];
        row_phase_adv    = (row_phase_inc >= step_eff) ? '0
                           : row_phase_inc[PHASE_W-1:0];
    end

    // ------------------------------------------------------------------
    // Frame state: advance on each pixel beat, clear when the result is loaded, not when it leaves
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg       <= '0;
            row_reg          <= '0;
            column_phase_reg <= '0;
            row_phase_reg    <= '0;
            sum_red_reg      <= '0;
            sum_green_reg    <= '0;
            sum_blue_reg     <= '0;
            taken_reg        <= '0;
        end
        else if (commit)
        begin
            column_reg       <= '0;
            row_reg          <= '0;
            column_phase_reg <= '0;
            row_phase_reg    <= '0;
            sum_red_reg      <= '0;
            sum_green_reg    <= '0;
            sum_blue_reg     <= '0;
            taken_reg        <= '0;
        end
        else if (in_accept)
        begin
            if (take)
            begin
                sum_red_reg   <= sum_red_reg + SUM_W'(red);
                sum_green_reg <= sum_green_reg + SUM_W'(green);
                sum_blue_reg  <= sum_blue_reg + SUM_W'(blue);
                taken_reg     <= taken_reg + CNT_W'(1);
            end
            // End of frame: position is cleared at commit, so only the sums matter
            if (end_of_line && !end_of_frame)
            begin
                if (row_valid && row_started)
                    row_phase_reg <= row_phase_adv;
                if (row_valid)
                    row_reg <= row_reg + ROW_W'(1);
                column_reg       <= '0;
                column_phase_reg <= '0;
            end
            else
            begin
                if (col_valid && col_started)
                    column_phase_reg <= column_phase_adv;
                if (col_valid)
                    column_reg <= column_reg + COL_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_PIXEL:
            begin
                if (in_valid && end_of_frame)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = count_zero ? ST_FINISH : ST_DIV;
            end
            ST_DIV:
            begin
                if (qbit_reg == '0)
                    state_next = (ch_reg == CH_BLUE) ? ST_FINISH : ST_LOAD;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_PIXEL;
            end
            default:
            begin
                state_next = ST_PIXEL;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        div_load = 1'b0;
        div_step = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            ST_PIXEL:  in_ready = 1'b1;
            ST_LOAD:   div_load = 1'b1;
            ST_DIV:    div_step = 1'b1;
            ST_FINISH: commit   = !out_valid_reg || out_ready;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_PIXEL;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // Shared restoring divider: (2*sum + count) / (2*count), 8 quotient bits
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]  sum_sel;
    logic [REM_W-1:0]  den_shift;
    logic [REM_W-1:0]  rem_trial;
    logic              fits;
    logic [CHAN_W-1:0] quot_next;
    chan_t             ch_next;

    always_comb
    begin
        case (ch_reg)
            CH_RED:   sum_sel = sum_red_reg;
            CH_GREEN: sum_sel = sum_green_reg;
            default:  sum_sel = sum_blue_reg;
        endcase
        case (ch_reg)
            CH_RED:   ch_next = CH_GREEN;
            CH_GREEN: ch_next = CH_BLUE;
            default:  ch_next = CH_RED;
        endcase
        den_shift = REM_W'({taken_reg, 1'b0}) << qbit_reg;
        fits      = rem_reg >= den_shift;
        rem_trial = rem_reg - den_shift;
        quot_next = quot_reg | (fits ? (CHAN_W'(1) << qbit_reg) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg   <= CH_RED;
            qbit_reg <= QBIT_TOP;
        end
        else if (commit)
        begin
            ch_reg <= CH_RED;
        end
        else if (div_step)
        begin
            qbit_reg <= qbit_reg - 3'd1;
            if (qbit_reg == '0)
                ch_reg <= ch_next;
        end
        else if (div_load)
        begin
            qbit_reg <= QBIT_TOP;
        end
    end

    // Datapath registers of the divider need no reset
    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            rem_reg  <= REM_W'({sum_sel, 1'b0}) + REM_W'(taken_reg);
            quot_reg <= '0;
            if (count_zero)
            begin
                res_red_reg   <= '0;
                res_green_reg <= '0;
                res_blue_reg  <= '0;
            end
        end
        else if (div_step)
        begin
            if (fits)
                rem_reg <= rem_trial;
            quot_reg <= quot_next;
            if (qbit_reg == '0)
            begin
                case (ch_reg)
                    CH_RED:   res_red_reg   <= quot_next;
                    CH_GREEN: res_green_reg <= quot_next;
                    default:  res_blue_reg  <= quot_next;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold the beat until out_ready
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            avg_red_reg      <= res_red_reg;
            avg_green_reg    <= res_green_reg;
            avg_blue_reg     <= res_blue_reg;
            sample_count_reg <= taken_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign avg_red      = avg_red_reg;
    assign avg_green    = avg_green_reg;
    assign avg_blue     = avg_blue_reg;
    assign sample_count = sample_count_reg;

endmodule

### hw/rtl/sravc_checker.sv
// Port-level checker for the screen region average color unit, with its bind.
// Depends on sravc_pkg and screen_region_average_color_unit.
module sravc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              end_of_frame,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [sravc_pkg::CHAN_W-1:0]      avg_red,
    input logic [sravc_pkg::CHAN_W-1:0]      avg_green,
    input logic [sravc_pkg::CHAN_W-1:0]      avg_blue,
    input logic [sravc_pkg::CNT_W-1:0]       sample_count
);
    import sravc_pkg::*;

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(avg_red)
            && $stable(avg_green) && $stable(avg_blue) && $stable(sample_count))
        else $error("result beat changed while stalled");

    // Empty region reports zero averages
    a_zero_avg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (sample_count == '0) |->
            (avg_red == '0) && (avg_green == '0) && (avg_blue == '0))
        else $error("nonzero average with no samples");

    // Average computation occupies the block after an end-of-frame beat
    a_busy_after_eof: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_frame |=> !in_ready ##1 !in_ready)
        else $error("pixel accepted during average computation");

    // Count never passes the limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample_count <= COUNT_LIMIT)
        else $error("sample count above limit");

endmodule

bind screen_region_average_color_unit sravc_checker u_sravc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .end_of_frame (end_of_frame),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .avg_red      (avg_red),
    .avg_green    (avg_green),
    .avg_blue     (avg_blue),
    .sample_count (sample_count)
);
